FILE: design/dtfe_pkg.sv
// Package for the date and time field editor: beat types, operation codes,
// field indexes and calendar limits.
// Depends on nothing; used by the top level, its checker and the testbench.
package dtfe_pkg;

   localparam logic [2:0] OP_UP     = 3'd0;
   localparam logic [2:0] OP_DOWN   = 3'd1;
   localparam logic [2:0] OP_PREV   = 3'd2;
   localparam logic [2:0] OP_NEXT   = 3'd3;
   localparam logic [2:0] OP_MODE   = 3'd4;
   localparam logic [2:0] OP_LOAD   = 3'd5;

   localparam logic [2:0] FLD_YEAR   = 3'd0;
   localparam logic [2:0] FLD_MONTH  = 3'd1;
   localparam logic [2:0] FLD_DAY    = 3'd2;
   localparam logic [2:0] FLD_HOUR   = 3'd3;
   localparam logic [2:0] FLD_MINUTE = 3'd4;
   localparam logic [2:0] FLD_SECOND = 3'd5;
   localparam logic [2:0] FLD_AMPM   = 3'd6;

   localparam logic [11:0] YEAR_MIN      = 12'd1970;
   localparam logic [11:0] YEAR_MAX      = 12'd2100;
   localparam logic [3:0]  MONTHS        = 4'd12;
   localparam logic [4:0]  DAYS_FEB      = 5'd28;
   localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;
   localparam logic [4:0]  DAYS_SHORT    = 5'd30;
   localparam logic [4:0]  DAYS_LONG     = 5'd31;
   localparam logic [4:0]  HOUR_NOON     = 5'd12;
   localparam logic [4:0]  HOUR_LAST     = 5'd23;
   localparam logic [5:0]  MINUTE_LAST   = 6'd59;

   typedef struct packed {
      logic [2:0]  op;
      logic        edit_locked;
      logic [11:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [4:0]  load_hour;
      logic [5:0]  load_minute;
      logic [5:0]  load_second;
   } dtfe_req_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  display_hour;
      logic        is_pm;
      logic [2:0]  field_sel;
      logic        mode_24;
      logic        changed;
   } dtfe_rsp_type;

endpackage

FILE: design/date_time_field_editor.sv
// Top level of the date and time field editor: input register, edit and
// normalisation logic, calendar state and result register.
// Depends on dtfe_pkg.
//
// Usage: each request beat is a button event (up, down, previous field,
// next field, toggle 24-hour mode) or a time load. Every request beat gives
// exactly one response beat with the full date and time after the event,
// the 12-hour display hour, the PM flag, the selected field and the mode.
// A request beat is taken into the input register, worked on from there,
// where the calendar state is updated, and shown from the result register.
// Throughput is one beat per cycle while the receiver does not stall; the
// calendar state is updated in the same cycle that the beat is worked on,
// so back-to-back beats see each other's edits. When the receiver stalls,
// the result register holds its beat and the input register fills;
// req_stall rises only once both are full. Reset empties both registers
// and sets the date to 1 January 1970, 00:00:00, year field selected,
// 12-hour mode.
module date_time_field_editor
   import dtfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dtfe_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dtfe_rsp_type rsp_data
);

   logic         in_valid_ff;
   dtfe_req_type in_data_ff;
   logic         out_valid_ff;
   dtfe_rsp_type out_data_ff;
   logic         advance;

   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [2:0]  field_ff, field_in;
   logic        mode_24_ff, mode_24_in;

   logic [12:0]       year_raw;
   logic [3:0]        month_raw;
   logic [5:0]        day_raw;
   logic signed [6:0] hour_raw;
   logic signed [6:0] minute_raw;
   logic signed [6:0] second_raw;
   logic              changed;
   logic              is_up;
   logic              leap;
   logic [4:0]        days;
   logic [2:0]        count;
   logic [2:0]        field_mod;
   logic [4:0]        display_hour;
   dtfe_rsp_type      rsp_in;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      is_up      = (in_data_ff.op == OP_UP);
      changed    = 1'b0;
      year_raw   = {1'b0, year_ff};
      month_raw  = month_ff;
      day_raw    = {1'b0, day_ff};
      hour_raw   = $signed({2'b00, hour_ff});
      minute_raw = $signed({1'b0, minute_ff});
      second_raw = $signed({1'b0, second_ff});
      field_in   = field_ff;
      mode_24_in = mode_24_ff;
      count      = mode_24_ff ? 3'd6 : 3'd7;
      field_mod  = (field_ff >= count) ? field_ff - count : field_ff;

      case (in_data_ff.op)
         OP_UP, OP_DOWN: begin
            if (!in_data_ff.edit_locked) begin
               changed = 1'b1;
               case (field_ff)
                  FLD_YEAR:   year_raw   = is_up ? year_raw + 13'd1 : year_raw - 13'd1;
                  FLD_MONTH:  month_raw  = is_up ? month_raw + 4'd1 : month_raw - 4'd1;
                  FLD_DAY:    day_raw    = is_up ? day_raw + 6'd1 : day_raw - 6'd1;
                  FLD_HOUR:   hour_raw   = is_up ? hour_raw + 7'sd1 : hour_raw - 7'sd1;
                  FLD_MINUTE: minute_raw = is_up ? minute_raw + 7'sd1 : minute_raw - 7'sd1;
                  FLD_SECOND: second_raw = is_up ? second_raw + 7'sd1 : second_raw - 7'sd1;
                  FLD_AMPM:   hour_raw   = is_up ? hour_raw + 7'sd12 : hour_raw - 7'sd12;
                  default:    changed    = 1'b0;
               endcase
            end
         end
         OP_PREV: begin
            field_in = (field_mod == 3'd0) ? count - 3'd1 : field_mod - 3'd1;
            changed  = 1'b1;
         end
         OP_NEXT: begin
            field_in = (field_mod == count - 3'd1) ? 3'd0 : field_mod + 3'd1;
            changed  = 1'b1;
         end
         OP_MODE: begin
            mode_24_in = !mode_24_ff;
            if (!mode_24_ff && field_ff >= FLD_AMPM) begin
               field_in = FLD_SECOND;
            end
            changed = 1'b1;
         end
         OP_LOAD: begin
            year_raw   = {1'b0, in_data_ff.load_year};
            month_raw  = in_data_ff.load_month;
            day_raw    = {1'b0, in_data_ff.load_day};
            hour_raw   = $signed({2'b00, in_data_ff.load_hour});
            minute_raw = $signed({1'b0, in_data_ff.load_minute});
            second_raw = $signed({1'b0, in_data_ff.load_second});
            changed    = 1'b1;
         end
         default: changed = 1'b0;
      endcase

      if (month_raw > MONTHS) begin
         month_in = month_raw - MONTHS;
      end else if (month_raw == 4'd0) begin
         month_in = MONTHS;
      end else begin
         month_in = month_raw;
      end

      if (year_raw > {1'b0, YEAR_MAX}) begin
         year_in = YEAR_MAX;
      end else if (year_raw < {1'b0, YEAR_MIN}) begin
         year_in = YEAR_MIN;
      end else begin
         year_in = year_raw[11:0];
      end

      // Within 1970..2100 the only century years are 2000, a leap year, and 2100.
      leap = (year_in[1:0] == 2'b00) && (year_in != YEAR_MAX);
      case (month_in)
         4'd2:                      days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         4'd4, 4'd6, 4'd9, 4'd11:   days = DAYS_SHORT;
         default:                   days = DAYS_LONG;
      endcase

      if (day_raw > {1'b0, days}) begin
         day_in = 5'(day_raw - {1'b0, days});
      end else if (day_raw == 6'd0) begin
         day_in = days;
      end else begin
         day_in = day_raw[4:0];
      end

      if (hour_raw > 7'sd23) begin
         hour_in = 5'(hour_raw - 7'sd24);
      end else if (hour_raw < 7'sd0) begin
         hour_in = 5'(hour_raw + 7'sd24);
      end else begin
         hour_in = hour_raw[4:0];
      end

      if (minute_raw > 7'sd59) begin
         minute_in = 6'(minute_raw - 7'sd60);
      end else if (minute_raw < 7'sd0) begin
         minute_in = 6'(minute_raw + 7'sd60);
      end else begin
         minute_in = minute_raw[5:0];
      end

      if (second_raw > 7'sd59) begin
         second_in = 6'(second_raw - 7'sd60);
      end else if (second_raw < 7'sd0) begin
         second_in = 6'(second_raw + 7'sd60);
      end else begin
         second_in = second_raw[5:0];
      end

      if (mode_24_in) begin
         display_hour = hour_in;
      end else if (hour_in == 5'd0) begin
         display_hour = HOUR_NOON;
      end else if (hour_in > HOUR_NOON) begin
         display_hour = hour_in - HOUR_NOON;
      end else begin
         display_hour = hour_in;
      end

      rsp_in.year           = year_in;
      rsp_in.month          = month_in;
      rsp_in.day            = day_in;
      rsp_in.hour           = hour_in;
      rsp_in.minute         = minute_in;
      rsp_in.second         = second_in;
      rsp_in.display_hour   = display_hour;
      rsp_in.is_pm          = (hour_in >= HOUR_NOON);
      rsp_in.field_sel      = field_in;
      rsp_in.mode_24        = mode_24_in;
      rsp_in.changed        = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         year_ff      <= YEAR_MIN;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         hour_ff      <= 5'd0;
         minute_ff    <= 6'd0;
         second_ff    <= 6'd0;
         field_ff     <= FLD_YEAR;
         mode_24_ff   <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               year_ff    <= year_in;
               month_ff   <= month_in;
               day_ff     <= day_in;
               hour_ff    <= hour_in;
               minute_ff  <= minute_in;
               second_ff  <= second_in;
               field_ff   <= field_in;
               mode_24_ff <= mode_24_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= rsp_in;
      end
   end

endmodule

FILE: design/dtfe_checker.sv
// Port-level checker for the date and time field editor, bound to the top level.
// Depends on dtfe_pkg and date_time_field_editor.
module dtfe_checker
   import dtfe_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input dtfe_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response beat changed or vanished.");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.year >= YEAR_MIN && rsp_data.year <= YEAR_MAX
         && rsp_data.month >= 4'd1 && rsp_data.month <= MONTHS
         && rsp_data.day >= 5'd1 && rsp_data.day <= DAYS_LONG
         && rsp_data.hour <= HOUR_LAST && rsp_data.minute <= MINUTE_LAST
         && rsp_data.second <= MINUTE_LAST)
      else $error("Response date or time out of range.");

   a_twelve_hour: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_pm == (rsp_data.hour >= HOUR_NOON)
         && (rsp_data.mode_24 ? rsp_data.display_hour == rsp_data.hour
            : rsp_data.display_hour >= 5'd1 && rsp_data.display_hour <= HOUR_NOON))
      else $error("Display hour or PM flag inconsistent with hour.");

   a_field_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.field_sel <= FLD_AMPM
         && (!rsp_data.mode_24 || rsp_data.field_sel <= FLD_SECOND))
      else $error("Selected field not available in the current mode.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("Response beat shown straight after reset.");

endmodule

bind date_time_field_editor dtfe_checker u_dtfe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: verif/tb_date_time_field_editor.sv
`timescale 1ns / 100ps
// Self-checking testbench for date_time_field_editor: a directed table of button events and time
// loads, then random bursts, checked against typed table values or a calendar predictor in this file.
// Depends on dtfe_pkg and the date_time_field_editor RTL.
module tb_date_time_field_editor;
   import dtfe_pkg::*;

   typedef struct {
      dtfe_req_type req;
      logic         typed;
      dtfe_rsp_type rsp;
   } stim_row_type;

   localparam int HOLD_CYCLES = 64;
   localparam int RANDOM_EDITS = 1325;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   dtfe_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   dtfe_rsp_type rsp_data;

   int           cal_year = YEAR_MIN;
   int           cal_month = 1;
   int           cal_day = 1;
   int           cal_hour = 0;
   int           cal_minute = 0;
   int           cal_second = 0;
   logic [2:0]   cal_field = FLD_YEAR;
   logic         cal_mode_24 = 1'b0;

   dtfe_rsp_type pending_displays[$];
   logic         pin_typed = 1'b0;
   dtfe_rsp_type pin_rsp = '0;
   int           burst_left = 0;
   int           accepted_beats = 0;
   int           mismatch_count = 0;
   logic         hold_done = 1'b0;

   date_time_field_editor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int days_in_month(int y, int m);
      if (m == 2) begin
         return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? DAYS_FEB_LEAP : DAYS_FEB;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return DAYS_SHORT;
      end
      return DAYS_LONG;
   endfunction

   function automatic int fold_once(int v, int lo, int span);
      if (v > lo + span - 1) begin
         return v - span;
      end
      if (v < lo) begin
         return v + span;
      end
      return v;
   endfunction

   function automatic void settle_calendar();
      cal_month = fold_once(cal_month, 1, MONTHS);
      if (cal_year > YEAR_MAX) begin
         cal_year = YEAR_MAX;
      end else if (cal_year < YEAR_MIN) begin
         cal_year = YEAR_MIN;
      end
      cal_day = fold_once(cal_day, 1, days_in_month(cal_year, cal_month));
      cal_hour = fold_once(cal_hour, 0, int'(HOUR_LAST) + 1);
      cal_minute = fold_once(cal_minute, 0, int'(MINUTE_LAST) + 1);
      cal_second = fold_once(cal_second, 0, int'(MINUTE_LAST) + 1);
   endfunction

   function automatic dtfe_rsp_type apply_button(dtfe_req_type r);
      dtfe_rsp_type o;
      int delta;
      int span;
      int f;
      int shown;
      logic done;
      done = 1'b0;
      span = cal_mode_24 ? int'(FLD_AMPM) : int'(FLD_AMPM) + 1;
      case (r.op)
         OP_UP, OP_DOWN: begin
            if (!r.edit_locked) begin
               delta = (r.op == OP_UP) ? 1 : -1;
               done = 1'b1;
               case (cal_field)
                  FLD_YEAR:   cal_year += delta;
                  FLD_MONTH:  cal_month += delta;
                  FLD_DAY:    cal_day += delta;
                  FLD_HOUR:   cal_hour += delta;
                  FLD_MINUTE: cal_minute += delta;
                  FLD_SECOND: cal_second += delta;
                  FLD_AMPM:   cal_hour += int'(HOUR_NOON) * delta;
                  default:    done = 1'b0;
               endcase
               if (done) begin
                  settle_calendar();
               end
            end
         end
         OP_PREV, OP_NEXT: begin
            f = int'(cal_field) % span;
            f = (r.op == OP_PREV) ? (f + span - 1) % span : (f + 1) % span;
            cal_field = f[2:0];
            done = 1'b1;
         end
         OP_MODE: begin
            cal_mode_24 = ~cal_mode_24;
            if (cal_mode_24 && cal_field >= FLD_AMPM) begin
               cal_field = FLD_SECOND;
            end
            done = 1'b1;
         end
         OP_LOAD: begin
            cal_year = r.load_year;
            cal_month = r.load_month;
            cal_day = r.load_day;
            cal_hour = r.load_hour;
            cal_minute = r.load_minute;
            cal_second = r.load_second;
            settle_calendar();
            done = 1'b1;
         end
         default: ;
      endcase
      shown = cal_hour;
      if (!cal_mode_24) begin
         if (shown == 0) begin
            shown = HOUR_NOON;
         end else if (shown > HOUR_NOON) begin
            shown -= HOUR_NOON;
         end
      end
      o.year = cal_year[11:0];
      o.month = cal_month[3:0];
      o.day = cal_day[4:0];
      o.hour = cal_hour[4:0];
      o.minute = cal_minute[5:0];
      o.second = cal_second[5:0];
      o.display_hour = shown[4:0];
      o.is_pm = (cal_hour >= HOUR_NOON);
      o.field_sel = cal_field;
      o.mode_24 = cal_mode_24;
      o.changed = done;
      return o;
   endfunction

   function automatic dtfe_req_type make_req(int op, int lock, int y, int mo, int d, int h,
                                             int mi, int s);
      dtfe_req_type r;
      r.op = op[2:0];
      r.edit_locked = lock[0];
      r.load_year = y[11:0];
      r.load_month = mo[3:0];
      r.load_day = d[4:0];
      r.load_hour = h[4:0];
      r.load_minute = mi[5:0];
      r.load_second = s[5:0];
      return r;
   endfunction

   function automatic stim_row_type typed_row(dtfe_req_type r, int y, int mo, int d, int h,
                                              int mi, int s, int dh, int pm, int fld, int m24,
                                              int ch);
      stim_row_type row;
      row.req = r;
      row.typed = 1'b1;
      row.rsp.year = y[11:0];
      row.rsp.month = mo[3:0];
      row.rsp.day = d[4:0];
      row.rsp.hour = h[4:0];
      row.rsp.minute = mi[5:0];
      row.rsp.second = s[5:0];
      row.rsp.display_hour = dh[4:0];
      row.rsp.is_pm = pm[0];
      row.rsp.field_sel = fld[2:0];
      row.rsp.mode_24 = m24[0];
      row.rsp.changed = ch[0];
      return row;
   endfunction

   function automatic stim_row_type open_row(int op);
      stim_row_type row;
      row.req = make_req(op, 0, 0, 0, 0, 0, 0, 0);
      row.typed = 1'b0;
      row.rsp = '0;
      return row;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(dtfe_req_type r, logic typed, dtfe_rsp_type rsp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      pin_typed = typed;
      pin_rsp = rsp;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      dtfe_rsp_type predicted;
      dtfe_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = apply_button(req_data);
            pending_displays.push_back(pin_typed ? pin_rsp : predicted);
            accepted_beats++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_displays.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_displays.pop_front();
               check_field("year", want.year, rsp_data.year);
               check_field("month", want.month, rsp_data.month);
               check_field("day", want.day, rsp_data.day);
               check_field("hour", want.hour, rsp_data.hour);
               check_field("minute", want.minute, rsp_data.minute);
               check_field("second", want.second, rsp_data.second);
               check_field("display_hour", want.display_hour, rsp_data.display_hour);
               check_field("is_pm", want.is_pm, rsp_data.is_pm);
               check_field("field_sel", want.field_sel, rsp_data.field_sel);
               check_field("mode_24", want.mode_24, rsp_data.mode_24);
               check_field("changed", want.changed, rsp_data.changed);
            end
         end
      end
   end

   // The receiver changes its stall pattern every stretch, and once holds off for a long
   // stretch so that both registers fill and the sender is stalled.
   initial begin
      int pattern;
      int stretch;
      int tick;
      tick = 0;
      @(negedge clock);
      forever begin
         if (!hold_done && accepted_beats >= 400) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         pattern = $urandom_range(0, 3);
         stretch = $urandom_range(20, 150);
         repeat (stretch) begin
            case (pattern)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (tick % 4 == 3);
            endcase
            tick++;
            @(negedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_date_time_field_editor: done, errors");
      $finish;
   end

   initial begin
      stim_row_type plan[$];
      dtfe_req_type r;
      int sent;
      int k;
      int op;
      int lock;
      int y, mo, d, h, mi, s;
      int waited;

      plan.push_back(typed_row(make_req(7, 0, 0, 0, 0, 0, 0, 0),
                               1970, 1, 1, 0, 0, 0, 12, 0, FLD_YEAR, 0, 0));
      plan.push_back(typed_row(make_req(OP_DOWN, 0, 0, 0, 0, 0, 0, 0),
                               1970, 1, 1, 0, 0, 0, 12, 0, FLD_YEAR, 0, 1));
      plan.push_back(typed_row(make_req(OP_UP, 1, 0, 0, 0, 0, 0, 0),
                               1970, 1, 1, 0, 0, 0, 12, 0, FLD_YEAR, 0, 0));
      plan.push_back(typed_row(make_req(OP_LOAD, 0, 4095, 15, 31, 31, 63, 63),
                               2100, 3, 31, 7, 3, 3, 7, 0, FLD_YEAR, 0, 1));
      plan.push_back(typed_row(make_req(OP_LOAD, 1, 0, 0, 0, 0, 0, 0),
                               1970, 12, 31, 0, 0, 0, 12, 0, FLD_YEAR, 0, 1));
      plan.push_back(typed_row(make_req(OP_LOAD, 0, 2100, 2, 29, 12, 0, 0),
                               2100, 2, 1, 12, 0, 0, 12, 1, FLD_YEAR, 0, 1));
      plan.push_back(typed_row(make_req(OP_UP, 0, 0, 0, 0, 0, 0, 0),
                               2100, 2, 1, 12, 0, 0, 12, 1, FLD_YEAR, 0, 1));
      plan.push_back(typed_row(make_req(OP_LOAD, 0, 2000, 2, 29, 23, 59, 59),
                               2000, 2, 29, 23, 59, 59, 11, 1, FLD_YEAR, 0, 1));
      plan.push_back(open_row(OP_LOAD));
      plan[$].req = make_req(OP_LOAD, 0, 2024, 1, 31, 10, 30, 30);
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_UP));
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_DOWN));
      plan.push_back(open_row(OP_DOWN));
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_DOWN));
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_UP));
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_UP));
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_UP));
      plan.push_back(open_row(OP_NEXT));
      plan.push_back(open_row(OP_PREV));
      plan.push_back(open_row(OP_MODE));
      plan.push_back(open_row(OP_MODE));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         send_beat(plan[i].req, plan[i].typed, plan[i].rsp);
      end

      sent = 0;
      while (sent < RANDOM_EDITS) begin
         k = $urandom_range(0, 99);
         if (k < 26) op = OP_UP;
         else if (k < 52) op = OP_DOWN;
         else if (k < 62) op = OP_PREV;
         else if (k < 74) op = OP_NEXT;
         else if (k < 79) op = OP_MODE;
         else if (k < 96) op = OP_LOAD;
         else op = $urandom_range(6, 7);
         lock = ($urandom_range(0, 6) == 0);
         if ($urandom_range(0, 3) == 0) begin
            y = $urandom_range(0, 4095);
            mo = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
            h = $urandom_range(0, 31);
            mi = $urandom_range(0, 63);
            s = $urandom_range(0, 63);
         end else begin
            case ($urandom_range(0, 7))
               0: y = 1972;
               1: y = 2000;
               2: y = 2096;
               3: y = 2100;
               default: y = $urandom_range(1966, 2104);
            endcase
            mo = $urandom_range(1, 12);
            d = $urandom_range(1, 31);
            h = $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            s = $urandom_range(0, 59);
         end
         r = make_req(op, lock, y, mo, d, h, mi, s);
         sent++;
         send_beat(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_displays.size() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
      if (pending_displays.size() > 0) begin
         $error("%0d response beats never arrived", pending_displays.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_date_time_field_editor: done, clean");
      end else begin
         $display("tb_date_time_field_editor: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/dtfe_pkg.sv
design/date_time_field_editor.sv
design/dtfe_checker.sv
verif/tb_date_time_field_editor.sv
